// File: rtl/stepper_homing_sequencer_macros.svh
// ---------------------------------------------------------------------------
// stepper homing sequencer assertion macros
// shared property forms for the checker, clocked on clk, idle in reset
// ---------------------------------------------------------------------------
`ifndef STEPPER_HOMING_SEQUENCER_MACROS_SVH
`define STEPPER_HOMING_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/shs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_pkg
// types, codes and reset values shared by the homing sequencer files
// ---------------------------------------------------------------------------
package shs_pkg;

  localparam int POS_W   = 32;
  localparam int MS_W    = 32;
  localparam int STEPS_W = 31;
  localparam int REQ_W   = 2;
  localparam int PHASE_W = 3;
  localparam int SPEED_W = 3;
  localparam int ERR_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ABORT = 2'd2;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE       = 3'd0,
    PH_SEEK       = 3'd1,
    PH_BACKOFF    = 3'd2,
    PH_REAPPROACH = 3'd3,
    PH_SETZERO    = 3'd4,
    PH_FINAL      = 3'd5,
    PH_DONE       = 3'd6,
    PH_ERROR      = 3'd7
  } phase_t;

  localparam logic [SPEED_W-1:0] SPD_STOP       = 3'd0;
  localparam logic [SPEED_W-1:0] SPD_SEEK       = 3'd1;
  localparam logic [SPEED_W-1:0] SPD_BACKOFF    = 3'd2;
  localparam logic [SPEED_W-1:0] SPD_REAPPROACH = 3'd3;
  localparam logic [SPEED_W-1:0] SPD_TRAVEL     = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE             = 4'd0;
  localparam logic [ERR_W-1:0] ERR_SEEK_TIMEOUT     = 4'd1;
  localparam logic [ERR_W-1:0] ERR_SEEK_TRAVEL      = 4'd2;
  localparam logic [ERR_W-1:0] ERR_BACKOFF_TIMEOUT  = 4'd3;
  localparam logic [ERR_W-1:0] ERR_BACKOFF_TRAVEL   = 4'd4;
  localparam logic [ERR_W-1:0] ERR_REAPPR_TIMEOUT   = 4'd5;
  localparam logic [ERR_W-1:0] ERR_REAPPR_TRAVEL    = 4'd6;
  localparam logic [ERR_W-1:0] ERR_FINAL_TIMEOUT    = 4'd7;
  localparam logic [ERR_W-1:0] ERR_ABORTED          = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_HOME_DIR         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEK_TIMEOUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEK_STEPS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEPS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MARGIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REAPPR_STEPS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_POSITION   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_TIMEOUT    = 3'd7;

  localparam logic [MS_W-1:0] BACKOFF_TIMEOUT_MS    = 32'd5000;
  localparam logic [MS_W-1:0] REAPPROACH_TIMEOUT_MS = 32'd10000;

  localparam logic [MS_W-1:0]    SEEK_TIMEOUT_RST  = 32'd20000;
  localparam logic [STEPS_W-1:0] SEEK_STEPS_RST    = 31'd100000;
  localparam logic [STEPS_W-1:0] BACKOFF_STEPS_RST = 31'd5000;
  localparam logic [STEPS_W-1:0] BACKOFF_MARGIN_RST = 31'd200;
  localparam logic [STEPS_W-1:0] REAPPR_STEPS_RST  = 31'd5000;
  localparam logic [MS_W-1:0]    FINAL_TIMEOUT_RST = 32'd20000;

endpackage

// File: rtl/shs_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs interfaces
// event, result and register write channels of the homing sequencer
// ---------------------------------------------------------------------------
interface shs_req_if import shs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [MS_W-1:0]         now_ms;
  logic signed [POS_W-1:0] motor_position;
  logic                    endstop_pressed;

  modport source (output valid, req_type, now_ms, motor_position, endstop_pressed,
                  input ready);
  modport sink (input valid, req_type, now_ms, motor_position, endstop_pressed,
                output ready);
endinterface

interface shs_res_if import shs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [PHASE_W-1:0]      phase;
  logic                    motor_enable;
  logic                    motor_dir;
  logic [SPEED_W-1:0]      speed_sel;
  logic                    zero_strobe;
  logic [ERR_W-1:0]        error_code;
  logic signed [POS_W-1:0] home_zero_pos;

  modport source (output valid, phase, motor_enable, motor_dir, speed_sel, zero_strobe,
                  error_code, home_zero_pos, input ready);
  modport sink (input valid, phase, motor_enable, motor_dir, speed_sel, zero_strobe,
                error_code, home_zero_pos, output ready);
endinterface

interface shs_cfg_if import shs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/stepper_homing_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper homing sequencer
// seek, backoff, reapproach, zero and final move with per-phase limits
// ---------------------------------------------------------------------------
// One event is taken every cycle unless stalled, and its result is on the
// result channel in the next cycle; the sequence state itself doubles as
// the result register, so an event is taken whenever that register is empty
// or its result is transferred in the same cycle. Each event needs one pass
// of the time and travel compares between the state registers and the
// inputs. Register writes are taken every cycle, one register per transfer.
module stepper_homing_sequencer
  import shs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  shs_req_if.sink   req,
  shs_res_if.source res,
  shs_cfg_if.sink   cfg
);

  logic                      home_dir;
  logic [MS_W-1:0]           seek_timeout_ms;
  logic [STEPS_W-1:0]        seek_steps_max;
  logic [STEPS_W-1:0]        backoff_steps_max;
  logic [STEPS_W-1:0]        backoff_margin;
  logic [STEPS_W-1:0]        reapproach_steps_max;
  logic signed [POS_W-1:0]   final_position;
  logic [MS_W-1:0]           final_timeout_ms;

  phase_t                    cur_phase, cur_phase_next;
  logic                      dir_reg, dir_reg_next;
  logic                      enable_reg, enable_reg_next;
  logic [SPEED_W-1:0]        speed_reg, speed_reg_next;
  logic signed [POS_W-1:0]   phase_start_pos, phase_start_pos_next;
  logic [MS_W-1:0]           phase_start_ms, phase_start_ms_next;
  logic                      released_flag, released_flag_next;
  logic signed [POS_W-1:0]   backoff_target, backoff_target_next;
  logic signed [POS_W-1:0]   zero_pos_reg, zero_pos_reg_next;
  logic [ERR_W-1:0]          err_reg, err_reg_next;
  logic                      strobe_reg, strobe_reg_next;
  logic                      out_valid;

  logic                      accept;
  logic [MS_W-1:0]           elapsed;
  logic [MS_W-1:0]           time_lim;
  logic [STEPS_W-1:0]        step_lim;
  logic signed [POS_W:0]     pos_ext;
  logic signed [POS_W:0]     diff;
  logic [POS_W:0]            travel;
  logic                      timed_out;
  logic                      over_travel;
  logic signed [POS_W:0]     target_sum;
  logic signed [POS_W-1:0]   target_sat;
  logic                      backoff_reached;
  logic                      final_reached;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || res.ready;
  assign cfg.ready = 1'b1;

  assign res.valid         = out_valid;
  assign res.phase         = cur_phase;
  assign res.motor_enable  = enable_reg;
  assign res.motor_dir     = dir_reg;
  assign res.speed_sel     = speed_reg;
  assign res.zero_strobe   = strobe_reg;
  assign res.error_code    = err_reg;
  assign res.home_zero_pos = zero_pos_reg;

  // per-phase limits
  always_comb begin
    unique case (cur_phase)
      PH_SEEK: begin
        time_lim = seek_timeout_ms;
        step_lim = seek_steps_max;
      end
      PH_BACKOFF: begin
        time_lim = BACKOFF_TIMEOUT_MS;
        step_lim = backoff_steps_max;
      end
      PH_REAPPROACH: begin
        time_lim = REAPPROACH_TIMEOUT_MS;
        step_lim = reapproach_steps_max;
      end
      PH_FINAL: begin
        time_lim = final_timeout_ms;
        step_lim = '1;
      end
      default: begin
        time_lim = '1;
        step_lim = '1;
      end
    endcase
  end

  assign elapsed     = req.now_ms - phase_start_ms;
  assign pos_ext     = {req.motor_position[POS_W-1], req.motor_position};
  assign diff        = pos_ext - {phase_start_pos[POS_W-1], phase_start_pos};
  assign travel      = diff[POS_W] ? $unsigned(-diff) : $unsigned(diff);
  assign timed_out   = elapsed > time_lim;
  assign over_travel = travel > {2'b00, step_lim};

  // backoff target, saturated to the signed position range
  assign target_sum = dir_reg ? pos_ext + $signed({2'b00, backoff_margin})
                              : pos_ext - $signed({2'b00, backoff_margin});
  always_comb begin
    if (target_sum[POS_W] != target_sum[POS_W-1]) begin
      target_sat = target_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                     : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      target_sat = target_sum[POS_W-1:0];
    end
  end

  assign backoff_reached = dir_reg ? (req.motor_position >= backoff_target)
                                   : (req.motor_position <= backoff_target);
  assign final_reached   = dir_reg ? (req.motor_position >= final_position)
                                   : (req.motor_position <= final_position);

  always_comb begin
    cur_phase_next       = cur_phase;
    dir_reg_next         = dir_reg;
    enable_reg_next      = enable_reg;
    speed_reg_next       = speed_reg;
    phase_start_pos_next = phase_start_pos;
    phase_start_ms_next  = phase_start_ms;
    released_flag_next   = released_flag;
    backoff_target_next  = backoff_target;
    zero_pos_reg_next    = zero_pos_reg;
    err_reg_next         = err_reg;
    strobe_reg_next      = 1'b0;

    priority if (req.req_type == REQ_START) begin
      err_reg_next         = ERR_NONE;
      cur_phase_next       = PH_SEEK;
      phase_start_pos_next = req.motor_position;
      phase_start_ms_next  = req.now_ms;
      enable_reg_next      = 1'b1;
      dir_reg_next         = home_dir;
      speed_reg_next       = SPD_SEEK;
    end else if (req.req_type == REQ_ABORT) begin
      speed_reg_next = SPD_STOP;
      cur_phase_next = PH_ERROR;
      err_reg_next   = ERR_ABORTED;
    end else if (req.req_type == REQ_TICK) begin
      unique case (cur_phase)
        PH_SEEK: begin
          priority if (timed_out) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_SEEK_TIMEOUT;
          end else if (over_travel) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_SEEK_TRAVEL;
          end else if (req.endstop_pressed) begin
            cur_phase_next       = PH_BACKOFF;
            phase_start_pos_next = req.motor_position;
            phase_start_ms_next  = req.now_ms;
            released_flag_next   = 1'b0;
            enable_reg_next      = 1'b1;
            dir_reg_next         = !home_dir;
            speed_reg_next       = SPD_BACKOFF;
          end else begin
          end
        end
        PH_BACKOFF: begin
          priority if (timed_out) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_BACKOFF_TIMEOUT;
          end else if (over_travel) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_BACKOFF_TRAVEL;
          end else if (!released_flag) begin
            if (!req.endstop_pressed) begin
              released_flag_next  = 1'b1;
              backoff_target_next = target_sat;
            end
          end else if (backoff_reached) begin
            cur_phase_next       = PH_REAPPROACH;
            phase_start_pos_next = req.motor_position;
            phase_start_ms_next  = req.now_ms;
            enable_reg_next      = 1'b1;
            dir_reg_next         = home_dir;
            speed_reg_next       = SPD_REAPPROACH;
          end else begin
          end
        end
        PH_REAPPROACH: begin
          priority if (timed_out) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_REAPPR_TIMEOUT;
          end else if (over_travel) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_REAPPR_TRAVEL;
          end else if (req.endstop_pressed) begin
            cur_phase_next       = PH_SETZERO;
            phase_start_pos_next = req.motor_position;
            phase_start_ms_next  = req.now_ms;
            speed_reg_next       = SPD_STOP;
          end else begin
          end
        end
        PH_SETZERO: begin
          zero_pos_reg_next    = req.motor_position;
          strobe_reg_next      = 1'b1;
          phase_start_pos_next = '0;
          phase_start_ms_next  = req.now_ms;
          if (final_position == '0) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_DONE;
          end else begin
            cur_phase_next  = PH_FINAL;
            enable_reg_next = 1'b1;
            dir_reg_next    = !final_position[POS_W-1];
            speed_reg_next  = SPD_TRAVEL;
          end
        end
        PH_FINAL: begin
          priority if (timed_out) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_ERROR;
            err_reg_next   = ERR_FINAL_TIMEOUT;
          end else if (final_reached) begin
            speed_reg_next = SPD_STOP;
            cur_phase_next = PH_DONE;
          end else begin
          end
        end
        default: begin
        end
      endcase
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_dir             <= 1'b0;
      seek_timeout_ms      <= SEEK_TIMEOUT_RST;
      seek_steps_max       <= SEEK_STEPS_RST;
      backoff_steps_max    <= BACKOFF_STEPS_RST;
      backoff_margin       <= BACKOFF_MARGIN_RST;
      reapproach_steps_max <= REAPPR_STEPS_RST;
      final_position       <= '0;
      final_timeout_ms     <= FINAL_TIMEOUT_RST;
      cur_phase            <= PH_IDLE;
      dir_reg              <= 1'b0;
      enable_reg           <= 1'b0;
      speed_reg            <= SPD_STOP;
      phase_start_pos      <= '0;
      phase_start_ms       <= '0;
      released_flag        <= 1'b0;
      backoff_target       <= '0;
      zero_pos_reg         <= '0;
      err_reg              <= ERR_NONE;
      strobe_reg           <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_HOME_DIR:       home_dir             <= cfg.data[0];
          CFG_SEEK_TIMEOUT:   seek_timeout_ms      <= cfg.data[MS_W-1:0];
          CFG_SEEK_STEPS:     seek_steps_max       <= cfg.data[STEPS_W-1:0];
          CFG_BACKOFF_STEPS:  backoff_steps_max    <= cfg.data[STEPS_W-1:0];
          CFG_BACKOFF_MARGIN: backoff_margin       <= cfg.data[STEPS_W-1:0];
          CFG_REAPPR_STEPS:   reapproach_steps_max <= cfg.data[STEPS_W-1:0];
          CFG_FINAL_POSITION: final_position       <= $signed(cfg.data[POS_W-1:0]);
          CFG_FINAL_TIMEOUT:  final_timeout_ms     <= cfg.data[MS_W-1:0];
        endcase
      end
      if (accept) begin
        cur_phase       <= cur_phase_next;
        dir_reg         <= dir_reg_next;
        enable_reg      <= enable_reg_next;
        speed_reg       <= speed_reg_next;
        phase_start_pos <= phase_start_pos_next;
        phase_start_ms  <= phase_start_ms_next;
        released_flag   <= released_flag_next;
        backoff_target  <= backoff_target_next;
        zero_pos_reg    <= zero_pos_reg_next;
        err_reg         <= err_reg_next;
        strobe_reg      <= strobe_reg_next;
        out_valid       <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/shs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_checker
// port-level checks on the homing sequencer, bound to the top level
// ---------------------------------------------------------------------------
`include "stepper_homing_sequencer_macros.svh"

module shs_checker
  import shs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [PHASE_W-1:0] res_phase,
  input logic               res_motor_enable,
  input logic [SPEED_W-1:0] res_speed_sel,
  input logic               res_zero_strobe,
  input logic [ERR_W-1:0]   res_error_code
);

  // every event transfer yields a result on the next cycle
  `SHS_ASSERT_NEXT(a_result_follows, req_valid && req_ready, res_valid, "event without result")

  // error code set exactly in the error phase
  `SHS_ASSERT_SAME(a_err_phase, res_valid,
    (res_phase == PH_ERROR) == (res_error_code != ERR_NONE), "error code and phase disagree")

  // zeroing only on entry to the final move or straight to done
  `SHS_ASSERT_SAME(a_zero_phase, res_valid && res_zero_strobe,
    res_phase == PH_FINAL || res_phase == PH_DONE, "zero strobe outside final or done")

  // a running motor is always enabled
  `SHS_ASSERT_SAME(a_speed_enable, res_valid && res_speed_sel != SPD_STOP,
    res_motor_enable, "speed selected while disabled")

  // stalled result holds
  `SHS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(res_phase) && $stable(res_error_code), "stalled result changed")

endmodule

bind stepper_homing_sequencer shs_checker u_shs_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_phase        (res.phase),
  .res_motor_enable (res.motor_enable),
  .res_speed_sel    (res.speed_sel),
  .res_zero_strobe  (res.zero_strobe),
  .res_error_code   (res.error_code)
);

// File: tb/stepper_homing_sequencer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_homing_sequencer_tb
// self-checking regression for the homing sequencer. a behavioural copy of
// the sequence predicts the status for every event transfer. each status
// transfer is then checked field by field, in order. directed runs cover
// idle requests, a full homing pass with time wrap, the limit boundaries
// and extreme settings. random runs then drive physically plausible homing
// passes across many settings, with injected faults and random idling.
// ---------------------------------------------------------------------------
module stepper_homing_sequencer_tb;
  import shs_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam logic signed [POS_W-1:0] POS_HI = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_LO = 32'sh8000_0000;

  typedef struct {
    logic [REQ_W-1:0]        req_type;
    logic [MS_W-1:0]         now_ms;
    logic signed [POS_W-1:0] pos;
    logic                    pressed;
  } motion_event_t;

  typedef struct {
    phase_t                  phase;
    logic                    enable;
    logic                    dir;
    logic [SPEED_W-1:0]      speed;
    logic                    strobe;
    logic [ERR_W-1:0]        err;
    logic signed [POS_W-1:0] zero_pos;
  } status_t;

  logic clk;
  logic rst;

  shs_req_if req ();
  shs_res_if res ();
  shs_cfg_if cfg ();

  stepper_homing_sequencer dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  // register copy
  logic                    cfg_home_dir;
  logic [MS_W-1:0]         cfg_seek_ms;
  logic [STEPS_W-1:0]      cfg_seek_steps;
  logic [STEPS_W-1:0]      cfg_backoff_steps;
  logic [STEPS_W-1:0]      cfg_margin;
  logic [STEPS_W-1:0]      cfg_reappr_steps;
  logic signed [POS_W-1:0] cfg_final_pos;
  logic [MS_W-1:0]         cfg_final_ms;

  // sequence state copy
  phase_t                  st_phase;
  logic                    st_dir;
  logic                    st_enable;
  logic [SPEED_W-1:0]      st_speed;
  logic signed [POS_W-1:0] st_start_pos;
  logic [MS_W-1:0]         st_start_ms;
  logic                    st_released;
  logic signed [POS_W-1:0] st_target;
  logic signed [POS_W-1:0] st_zero_pos;
  logic [ERR_W-1:0]        st_err;

  status_t expected_status[$];
  int      mismatches   = 0;
  int      items_taken  = 0;
  int      stall_count  = 0;
  int      src_idle_pct = 0;
  int      rcv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
    if (v > longint'(POS_HI)) return POS_HI;
    if (v < longint'(POS_LO)) return POS_LO;
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] step_toward(logic signed [POS_W-1:0] from,
                                                          logic up, longint amount);
    return clamp_pos(up ? longint'(from) + amount : longint'(from) - amount);
  endfunction

  function automatic void fail_sequence(logic [ERR_W-1:0] code);
    st_speed = SPD_STOP;
    st_phase = PH_ERROR;
    st_err   = code;
  endfunction

  function automatic void begin_phase(phase_t ph, logic signed [POS_W-1:0] pos,
                                      logic [MS_W-1:0] now);
    st_phase     = ph;
    st_start_pos = pos;
    st_start_ms  = now;
    case (ph)
      PH_SEEK: begin
        st_enable = 1'b1;
        st_dir    = cfg_home_dir;
        st_speed  = SPD_SEEK;
      end
      PH_BACKOFF: begin
        st_released = 1'b0;
        st_enable   = 1'b1;
        st_dir      = ~cfg_home_dir;
        st_speed    = SPD_BACKOFF;
      end
      PH_REAPPROACH: begin
        st_enable = 1'b1;
        st_dir    = cfg_home_dir;
        st_speed  = SPD_REAPPROACH;
      end
      PH_SETZERO: st_speed = SPD_STOP;
      PH_FINAL: begin
        if (pos == cfg_final_pos) begin
          st_speed = SPD_STOP;
          st_phase = PH_DONE;
        end else begin
          st_enable = 1'b1;
          st_dir    = (pos < cfg_final_pos);
          st_speed  = SPD_TRAVEL;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic status_t step_sequencer(motion_event_t ev);
    status_t         r;
    logic [MS_W-1:0] elapsed;
    longint          travel;
    longint          aim;
    logic            hit;
    r.strobe = 1'b0;
    elapsed  = ev.now_ms - st_start_ms;
    travel   = longint'(ev.pos) - longint'(st_start_pos);
    if (travel < 0) travel = -travel;
    if (ev.req_type == REQ_START) begin
      st_err = ERR_NONE;
      begin_phase(PH_SEEK, ev.pos, ev.now_ms);
    end else if (ev.req_type == REQ_ABORT) begin
      fail_sequence(ERR_ABORTED);
    end else if (ev.req_type == REQ_TICK) begin
      case (st_phase)
        PH_SEEK: begin
          if (elapsed > cfg_seek_ms) fail_sequence(ERR_SEEK_TIMEOUT);
          else if (travel > longint'(cfg_seek_steps)) fail_sequence(ERR_SEEK_TRAVEL);
          else if (ev.pressed) begin_phase(PH_BACKOFF, ev.pos, ev.now_ms);
        end
        PH_BACKOFF: begin
          if (elapsed > BACKOFF_TIMEOUT_MS) fail_sequence(ERR_BACKOFF_TIMEOUT);
          else if (travel > longint'(cfg_backoff_steps)) fail_sequence(ERR_BACKOFF_TRAVEL);
          else if (!st_released) begin
            if (!ev.pressed) begin
              aim = st_dir ? longint'(ev.pos) + longint'(cfg_margin)
                           : longint'(ev.pos) - longint'(cfg_margin);
              st_released = 1'b1;
              st_target   = clamp_pos(aim);
            end
          end else begin
            hit = st_dir ? (ev.pos >= st_target) : (ev.pos <= st_target);
            if (hit) begin_phase(PH_REAPPROACH, ev.pos, ev.now_ms);
          end
        end
        PH_REAPPROACH: begin
          if (elapsed > REAPPROACH_TIMEOUT_MS) fail_sequence(ERR_REAPPR_TIMEOUT);
          else if (travel > longint'(cfg_reappr_steps)) fail_sequence(ERR_REAPPR_TRAVEL);
          else if (ev.pressed) begin_phase(PH_SETZERO, ev.pos, ev.now_ms);
        end
        PH_SETZERO: begin
          st_zero_pos = ev.pos;
          r.strobe    = 1'b1;
          begin_phase(PH_FINAL, '0, ev.now_ms);
        end
        PH_FINAL: begin
          if (elapsed > cfg_final_ms) fail_sequence(ERR_FINAL_TIMEOUT);
          else begin
            hit = st_dir ? (ev.pos >= cfg_final_pos) : (ev.pos <= cfg_final_pos);
            if (hit) begin
              st_speed = SPD_STOP;
              st_phase = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
    r.phase    = st_phase;
    r.enable   = st_enable;
    r.dir      = st_dir;
    r.speed    = st_speed;
    r.err      = st_err;
    r.zero_pos = st_zero_pos;
    return r;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_HOME_DIR:       cfg_home_dir      = data[0];
      CFG_SEEK_TIMEOUT:   cfg_seek_ms       = data;
      CFG_SEEK_STEPS:     cfg_seek_steps    = data[STEPS_W-1:0];
      CFG_BACKOFF_STEPS:  cfg_backoff_steps = data[STEPS_W-1:0];
      CFG_BACKOFF_MARGIN: cfg_margin        = data[STEPS_W-1:0];
      CFG_REAPPR_STEPS:   cfg_reappr_steps  = data[STEPS_W-1:0];
      CFG_FINAL_POSITION: cfg_final_pos     = data;
      CFG_FINAL_TIMEOUT:  cfg_final_ms      = data;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // transfer monitor, status check and watchdog
  always @(posedge clk) begin : monitor
    status_t       got;
    status_t       want;
    motion_event_t ev;
    logic          moved;
    if (!rst) begin
      moved = 1'b0;
      if (res.valid && res.ready) begin
        moved        = 1'b1;
        got.phase    = phase_t'(res.phase);
        got.enable   = res.motor_enable;
        got.dir      = res.motor_dir;
        got.speed    = res.speed_sel;
        got.strobe   = res.zero_strobe;
        got.err      = res.error_code;
        got.zero_pos = res.home_zero_pos;
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: status transfer with no event pending", $time);
        end else begin
          want = expected_status.pop_front();
          check_field("phase", longint'(want.phase), longint'(got.phase));
          check_field("motor_enable", longint'(want.enable), longint'(got.enable));
          check_field("motor_dir", longint'(want.dir), longint'(got.dir));
          check_field("speed_sel", longint'(want.speed), longint'(got.speed));
          check_field("zero_strobe", longint'(want.strobe), longint'(got.strobe));
          check_field("error_code", longint'(want.err), longint'(got.err));
          check_field("home_zero_pos", longint'(want.zero_pos), longint'(got.zero_pos));
        end
      end
      if (cfg.valid && cfg.ready) begin
        moved = 1'b1;
        apply_register(cfg.index, cfg.data);
      end
      if (req.valid && req.ready) begin
        moved       = 1'b1;
        ev.req_type = req.req_type;
        ev.now_ms   = req.now_ms;
        ev.pos      = req.motor_position;
        ev.pressed  = req.endstop_pressed;
        expected_status.push_back(step_sequencer(ev));
        items_taken++;
      end
      stall_count = moved ? 0 : stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("stepper_homing_sequencer regression: fail");
        $finish;
      end
    end
  end

  task automatic send_event(logic [REQ_W-1:0] kind, logic [MS_W-1:0] now,
                            logic signed [POS_W-1:0] pos, logic pressed);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid           <= 1'b1;
    req.req_type        <= kind;
    req.now_ms          <= now;
    req.motor_position  <= pos;
    req.endstop_pressed <= pressed;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // unused upper data bits are randomised, the block must drop them
  task automatic program_settings(logic dir, logic [MS_W-1:0] seek_ms,
                                  logic [STEPS_W-1:0] seek_steps, backoff_steps, margin,
                                  reappr_steps, logic signed [POS_W-1:0] final_pos,
                                  logic [MS_W-1:0] final_ms);
    wait_idle();
    write_register(CFG_HOME_DIR, {31'($urandom()), dir});
    write_register(CFG_SEEK_TIMEOUT, seek_ms);
    write_register(CFG_SEEK_STEPS, {1'($urandom_range(0, 1)), seek_steps});
    write_register(CFG_BACKOFF_STEPS, {1'($urandom_range(0, 1)), backoff_steps});
    write_register(CFG_BACKOFF_MARGIN, {1'($urandom_range(0, 1)), margin});
    write_register(CFG_REAPPR_STEPS, {1'($urandom_range(0, 1)), reappr_steps});
    write_register(CFG_FINAL_POSITION, final_pos);
    write_register(CFG_FINAL_TIMEOUT, final_ms);
    cfg.valid <= 1'b0;
  endtask

  task automatic choose_settings(int style);
    logic signed [POS_W-1:0] fpos;
    case ($urandom_range(0, 4))
      0:       fpos = '0;
      1:       fpos = $urandom_range(0, 4000) - 2000;
      2:       fpos = POS_LO;
      3:       fpos = POS_HI;
      default: fpos = $urandom_range(0, 200) - 100;
    endcase
    case (style)
      3: program_settings(1'($urandom_range(0, 1)), '0, '0, '0, '0, '0, '0, '0);
      4: program_settings(1'($urandom_range(0, 1)), '1, '1, '1, '1, '1,
                          $urandom_range(0, 1) ? POS_HI : POS_LO, '1);
      5: program_settings(1'($urandom_range(0, 1)), $urandom(), 31'($urandom()),
                          31'($urandom()), 31'($urandom()), 31'($urandom()), $urandom(),
                          $urandom());
      default: program_settings(1'($urandom_range(0, 1)), $urandom_range(200, 5000),
                                31'($urandom_range(20, 2000)), 31'($urandom_range(20, 2000)),
                                31'($urandom_range(0, 300)), 31'($urandom_range(20, 2000)),
                                fpos, $urandom_range(200, 5000));
    endcase
  endtask

  // one homing pass: the motor follows the commanded direction, faults optional
  task automatic run_homing(int fault_pct);
    logic [REQ_W-1:0]        kind;
    logic [MS_W-1:0]         now;
    logic signed [POS_W-1:0] pos;
    logic                    pressed;
    logic [MS_W-1:0]         span_ms;
    longint                  span_steps;
    logic                    zeroing;
    int                      ticks;
    now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom();
    pos = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 20000) - 10000;
    send_event(REQ_START, now, pos, 1'($urandom_range(0, 1)));
    ticks = 0;
    while (ticks < 60 && st_phase >= PH_SEEK && st_phase <= PH_FINAL) begin
      kind       = REQ_TICK;
      now        = now + $urandom_range(0, 20);
      pressed    = 1'b0;
      span_ms    = cfg_final_ms;
      span_steps = 0;
      case (st_phase)
        PH_SEEK: begin
          span_ms    = cfg_seek_ms;
          span_steps = longint'(cfg_seek_steps);
          pos        = step_toward(pos, st_dir, longint'($urandom_range(0, 30)));
          pressed    = ($urandom_range(0, 3) == 0);
        end
        PH_BACKOFF: begin
          span_ms    = BACKOFF_TIMEOUT_MS;
          span_steps = longint'(cfg_backoff_steps);
          if (!st_released) begin
            pos     = step_toward(pos, st_dir, longint'($urandom_range(0, 30)));
            pressed = ($urandom_range(0, 2) != 0);
          end else if ($urandom_range(0, 1) == 0) begin
            pos = step_toward(st_target, st_dir, longint'($urandom_range(0, 3)));
          end else begin
            pos     = step_toward(pos, st_dir, longint'($urandom_range(0, 40)));
            pressed = ($urandom_range(0, 5) == 0);
          end
        end
        PH_REAPPROACH: begin
          span_ms    = REAPPROACH_TIMEOUT_MS;
          span_steps = longint'(cfg_reappr_steps);
          pos        = step_toward(pos, st_dir, longint'($urandom_range(0, 30)));
          pressed    = ($urandom_range(0, 2) == 0);
        end
        PH_SETZERO: pressed = 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 2) == 0)
            pos = step_toward(cfg_final_pos, st_dir, longint'($urandom_range(0, 3)));
          else
            pos = step_toward(pos, st_dir, longint'($urandom_range(0, 500)));
        end
      endcase
      if ($urandom_range(0, 99) < fault_pct) begin
        case ($urandom_range(0, 5))
          0:       now = st_start_ms + span_ms + $urandom_range(0, 1);
          1:       pos = step_toward(st_start_pos, st_dir, span_steps + $urandom_range(0, 1));
          2:       kind = REQ_ABORT;
          3:       kind = REQ_START;
          4:       kind = REQ_RESERVED;
          default: now = now + $urandom();
        endcase
      end
      zeroing = (st_phase == PH_SETZERO) && (kind == REQ_TICK);
      send_event(kind, now, pos, pressed);
      if (zeroing) pos = '0;
      ticks++;
    end
    repeat ($urandom_range(0, 1)) send_event(REQ_TICK, now + 1, pos, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_idle_requests();
    send_event(REQ_TICK, '0, '0, 1'b0);
    send_event(REQ_RESERVED, '1, POS_HI, 1'b1);
    send_event(REQ_ABORT, '0, POS_LO, 1'b0);
    send_event(REQ_TICK, 32'd100, '0, 1'b1);
    send_event(REQ_START, '1, -32'sd1, 1'b1);
    send_event(REQ_ABORT, '0, '0, 1'b0);
  endtask

  // reset settings: toward the endstop is decreasing, margin 200, final 0
  task automatic test_directed_homing();
    logic [MS_W-1:0] t0;
    t0 = 32'hFFFF_FF00;
    send_event(REQ_START, t0, 32'sd1000, 1'b0);
    send_event(REQ_TICK, t0 + 50, 32'sd950, 1'b0);
    send_event(REQ_TICK, t0 + 300, 32'sd800, 1'b1);
    send_event(REQ_TICK, t0 + 320, 32'sd850, 1'b1);
    send_event(REQ_TICK, t0 + 340, 32'sd900, 1'b0);
    send_event(REQ_TICK, t0 + 360, 32'sd1099, 1'b0);
    send_event(REQ_TICK, t0 + 380, 32'sd1100, 1'b1);
    send_event(REQ_TICK, t0 + 400, 32'sd1000, 1'b1);
    send_event(REQ_TICK, t0 + 420, 32'sd12345, 1'b0);
    send_event(REQ_TICK, t0 + 440, '0, 1'b0);
  endtask

  // timeout and travel exactly at the limit, then both past it, then travel alone
  task automatic test_limit_boundaries();
    send_event(REQ_START, 32'd1000, '0, 1'b0);
    send_event(REQ_TICK, 32'd21000, -32'sd100000, 1'b0);
    send_event(REQ_TICK, 32'd21001, -32'sd100001, 1'b0);
    send_event(REQ_START, 32'd5000, '0, 1'b0);
    send_event(REQ_TICK, 32'd5000, 32'sd100001, 1'b0);
  endtask

  // backoff target clamps at the negative end, final move to the far end
  task automatic test_extreme_settings();
    program_settings(1'b1, '1, '1, '1, '1, '1, POS_LO, '1);
    send_event(REQ_START, '0, -32'sd2147483000, 1'b0);
    send_event(REQ_TICK, 32'd10, -32'sd2147483000, 1'b1);
    send_event(REQ_TICK, 32'd20, -32'sd2147483000, 1'b0);
    send_event(REQ_TICK, 32'd30, POS_LO, 1'b0);
    send_event(REQ_TICK, 32'd40, POS_LO + 10, 1'b1);
    send_event(REQ_TICK, 32'd50, 32'sd7, 1'b0);
    send_event(REQ_TICK, 32'd60, POS_LO, 1'b0);
  endtask

  task automatic test_random_homing(int src_pct, int rcv_pct, int count);
    int goal;
    int next_cfg;
    src_idle_pct = src_pct;
    rcv_idle_pct = rcv_pct;
    goal         = items_taken + count;
    next_cfg     = items_taken;
    while (items_taken < goal) begin
      if (items_taken >= next_cfg) begin
        choose_settings($urandom_range(0, 5));
        next_cfg = items_taken + 120;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          send_event(REQ_W'($urandom_range(0, 3)), $urandom(), $urandom(),
                     1'($urandom_range(0, 1)));
      end else begin
        run_homing($urandom_range(0, 10));
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    req.valid           = 1'b0;
    req.req_type        = REQ_TICK;
    req.now_ms          = '0;
    req.motor_position  = '0;
    req.endstop_pressed = 1'b0;
    res.ready           = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_HOME_DIR;
    cfg.data            = '0;
    cfg_home_dir        = 1'b0;
    cfg_seek_ms         = SEEK_TIMEOUT_RST;
    cfg_seek_steps      = SEEK_STEPS_RST;
    cfg_backoff_steps   = BACKOFF_STEPS_RST;
    cfg_margin          = BACKOFF_MARGIN_RST;
    cfg_reappr_steps    = REAPPR_STEPS_RST;
    cfg_final_pos       = '0;
    cfg_final_ms        = FINAL_TIMEOUT_RST;
    st_phase            = PH_IDLE;
    st_dir              = 1'b0;
    st_enable           = 1'b0;
    st_speed            = SPD_STOP;
    st_start_pos        = '0;
    st_start_ms         = '0;
    st_released         = 1'b0;
    st_target           = '0;
    st_zero_pos         = '0;
    st_err              = ERR_NONE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_idle_pct = 31;
    rcv_idle_pct = 70;
    test_idle_requests();
    test_directed_homing();
    test_limit_boundaries();
    test_extreme_settings();
    test_random_homing(31, 70, 400);
    test_random_homing(70, 31, 400);
    test_random_homing(0, 0, 400);
    wait_idle();
    if (mismatches == 0) begin
      $display("stepper_homing_sequencer regression: pass");
    end else begin
      $display("stepper_homing_sequencer regression: fail");
    end
    $finish;
  end

endmodule
